>>> rtl/core/shab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package shab_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  localparam logic [31:0] START_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
    rotr = (x >> r) | (x << (32 - r));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/shab_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module shab_queue #(
  parameter int Depth = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire shab_pkg::item_t      in_item,
  output shab_pkg::queue_head_t     head,
  input  wire logic                 pop
);
  import shab_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           slots [Depth];
  logic [PtrW-1:0] rd_ptr, wr_ptr;
  logic [CntW-1:0] count;
  logic            push, take;

  assign in_stall = (count == FullCnt);
  assign push = in_valid && !in_stall;
  assign take = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/shab_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module shab_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire shab_pkg::queue_head_t head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [31:0]               digest_word,
  output logic [2:0]                word_index,
  output logic                      digest_last
);
  import shab_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    NX_IDLE   = 2'd0,
    NX_PAD    = 2'd1,
    NX_LENBLK = 2'd2,
    NX_OUT    = 2'd3
  } after_t;

  state_t      st, st_next;
  after_t      after, after_next;
  logic        len_only, len_only_next;
  logic [5:0]  fill, fill_next;
  logic [63:0] length_bits, length_bits_next;
  logic [5:0]  rnd, rnd_next;
  logic [2:0]  idx, idx_next;
  logic        ov_next;
  logic [31:0] chain [8];
  logic [31:0] chain_next [8];
  logic [31:0] w [16];
  logic [31:0] w_next [16];
  logic [31:0] v [8];
  logic [31:0] v_next [8];
  logic [31:0] dig [8];
  logic [31:0] dig_next [8];
  logic [31:0] t1, t2;
  logic        place_len;
  logic [5:0]  bidx;

  assign digest_word = dig[0];
  assign word_index = idx;
  assign digest_last = (idx == 3'd7);
  assign pop = (st == ST_IDLE) && head.valid;

  always_comb begin
    st_next = st;
    after_next = after;
    len_only_next = len_only;
    fill_next = fill;
    length_bits_next = length_bits;
    rnd_next = rnd;
    idx_next = idx;
    ov_next = out_valid;
    chain_next = chain;
    w_next = w;
    v_next = v;
    dig_next = dig;
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    place_len = len_only || (fill < LEN_POS);
    bidx = '0;
    case (st)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.item.byte_present) begin
            w_next[fill[5:2]][8*(3 - fill[1:0]) +: 8] = head.item.data_byte;
            length_bits_next = length_bits + 64'd8;
            fill_next = fill + 1'b1;
          end
          if (head.item.byte_present && (fill == 6'd63)) begin
            // full block: compress, then pad if the message ends here
            after_next = head.item.end_of_message ? NX_PAD : NX_IDLE;
            len_only_next = 1'b0;
            v_next = chain;
            rnd_next = '0;
            st_next = ST_ROUND;
          end else if (head.item.end_of_message) begin
            len_only_next = 1'b0;
            st_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        for (int j = 0; j < 16; j++) begin
          for (int b = 0; b < 4; b++) begin
            bidx = 6'(j * 4 + b);
            if (len_only || (bidx > fill)) begin
              w_next[j][8*(3 - b) +: 8] = 8'h00;
            end else if (bidx == fill) begin
              w_next[j][8*(3 - b) +: 8] = PAD_MARK;
            end
          end
        end
        if (place_len) begin
          w_next[14] = length_bits[63:32];
          w_next[15] = length_bits[31:0];
        end
        after_next = place_len ? NX_OUT : NX_LENBLK;
        v_next = chain;
        rnd_next = '0;
        st_next = ST_ROUND;
      end
      ST_ROUND: begin
        v_next[7] = v[6];
        v_next[6] = v[5];
        v_next[5] = v[4];
        v_next[4] = v[3] + t1;
        v_next[3] = v[2];
        v_next[2] = v[1];
        v_next[1] = v[0];
        v_next[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_next[i] = w[i + 1];
        end
        w_next[15] = ssig1(w[14]) + w[9] + ssig0(w[1]) + w[0];
        rnd_next = rnd + 1'b1;
        if (rnd == 6'd63) begin
          st_next = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_next[i] = chain[i] + v[i];
        end
        case (after)
          NX_IDLE: st_next = ST_IDLE;
          NX_PAD: begin
            len_only_next = 1'b0;
            st_next = ST_PAD;
          end
          NX_LENBLK: begin
            len_only_next = 1'b1;
            st_next = ST_PAD;
          end
          NX_OUT: begin
            // hand the digest to the output register, restart the message
            for (int i = 0; i < 8; i++) begin
              dig_next[i] = chain[i] + v[i];
              chain_next[i] = START_CHAIN[i];
            end
            length_bits_next = '0;
            fill_next = '0;
            idx_next = '0;
            ov_next = 1'b1;
            st_next = ST_OUT;
          end
          default: st_next = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (!out_stall) begin
          for (int i = 0; i < 7; i++) begin
            dig_next[i] = dig[i + 1];
          end
          idx_next = idx + 1'b1;
          if (idx == 3'd7) begin
            ov_next = 1'b0;
            st_next = ST_IDLE;
          end
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    w <= w_next;
    v <= v_next;
    dig <= dig_next;
    rnd <= rnd_next;
    idx <= idx_next;
    after <= after_next;
    len_only <= len_only_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      out_valid <= 1'b0;
      fill <= '0;
      length_bits <= '0;
      chain <= START_CHAIN;
    end else begin
      st <= st_next;
      out_valid <= ov_next;
      fill <= fill_next;
      length_bits <= length_bits_next;
      chain <= chain_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake           | payload
// input   | in_valid / in_stall   | data_byte, byte_present, end_of_message
// output  | out_valid / out_stall | digest_word, word_index, digest_last
//
// A byte item passes through the input queue, then lands in the block word register.
// A full block then runs 64 rounds on one round unit and one chain add.
// End of message: one or two padding blocks, each a pad step, 64 rounds and one chain add,
// then eight digest transfers, one per cycle while out_stall is low.
// Reset (rst, synchronous) empties the queue and loads the initial hash values.
// The queue keeps taking items while the engine works or the digest waits, until it is full.
module sha256_byte_stream_hasher_unit #(
  parameter int QueueDepth = shab_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             digest_last
);
  import shab_pkg::*;

  item_t       in_item;
  queue_head_t head;
  logic        pop;

  assign in_item.data_byte = data_byte;
  assign in_item.byte_present = byte_present;
  assign in_item.end_of_message = end_of_message;

  shab_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .head(head), .pop(pop)
  );

  shab_engine u_engine (
    .clk(clk), .rst(rst), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .digest_last(digest_last)
  );

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("digest valid right after reset");

  a_words_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !digest_last) |=> out_valid)
    else $error("digest words not contiguous");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && digest_last) |=> !out_valid)
    else $error("new digest without compression");

  a_no_pop_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !pop)
    else $error("item taken while digest pending");

endmodule
`default_nettype wire
